// ===== sv/line_substring_filter_unit_macros.svh =====
// ---------------------------------------------------------------------------
// line_substring_filter_unit_macros
// Assertion macros used by the line filter top module.
// ---------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_FILTER_UNIT_MACROS_SVH
`define LINE_SUBSTRING_FILTER_UNIT_MACROS_SVH

// checked only out of reset
`define LSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define LSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/lsf_pkg.sv =====
// ---------------------------------------------------------------------------
// lsf_pkg
// Types, constants and helpers for the line substring filter.
// ---------------------------------------------------------------------------
package lsf_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int PAT_IDX_W   = $clog2(PATTERN_MAX);
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = LEN_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [7:0]       NEWLINE = 8'd10;

    // actions
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TEXT = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    // result kinds
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_SELECT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

    typedef struct packed {
        logic             ignore_case;
        logic             invert_select;
        logic             count_only;
        logic [LEN_W-1:0] pattern_length;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           action;
        logic [7:0]           byte_value;
        logic [PAT_IDX_W-1:0] pattern_index;
    } t_item;

    typedef struct packed {
        logic             line_hit;
        logic             len_zero;
    } t_match_status;

    typedef struct packed {
        logic             result_kind;
        logic [CNT_W-1:0] line_number;
        logic             line_selected;
        logic [CNT_W-1:0] selected_count;
    } t_result;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== sv/line_substring_filter_unit.sv =====
// ---------------------------------------------------------------------------
// line_substring_filter_unit
// Grep-style fixed-string line filter over a byte stream.
// ---------------------------------------------------------------------------
// Usage: load the pattern with load transfers (tuser 0, byte and index in
// tdata) and set pattern_length through the config port while idle. Then
// stream text transfers (tuser 1) and close the stream with an end transfer
// (tuser 2). A newline or the end transfer closes a line and gives a line
// report (tuser 0) on the master side; in count mode the end transfer gives
// one count result (tuser 1) instead. Every result carries tlast high.
// A transfer loads the input register, and its result is then loaded into the
// result register. Throughput: one transfer per cycle while the master side
// does not stall with a result pending, set by the shift-and update of the
// 64-bit match vector.
// When the master side stalls with a result pending, the slave side keeps
// taking transfers that produce no result; one that does waits in the
// input register and tready drops.
// Reset clears the config registers, match state and counters; the pattern
// store keeps its contents and is undefined until loaded.
// ---------------------------------------------------------------------------
`include "line_substring_filter_unit_macros.svh"

module line_substring_filter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // byte_value[7:0], pattern_index[13:8]
    input  logic [1:0]                     s_axis_tuser,  // action[1:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [71:0]                    m_axis_tdata,  // line_number[31:0], line_selected[32],
                                                          // selected_count[64:33]
    output logic                           m_axis_tuser,  // result_kind[0]
    output logic                           m_axis_tlast
);
    import lsf_pkg::*;

    t_cfg          r_cfg;
    logic          r_in_valid;
    t_item         r_in_item;
    logic          r_out_valid;
    t_result       r_out;
    t_item         in_item;
    t_match_status status;
    logic          has_result;
    t_result       result;
    logic          stall;
    logic          adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IGNORE_CASE:    r_cfg.ignore_case    <= i_cfg_data[0];
                REG_INVERT_SELECT:  r_cfg.invert_select  <= i_cfg_data[0];
                REG_COUNT_ONLY:     r_cfg.count_only     <= i_cfg_data[0];
                REG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_item.action        = s_axis_tuser;
    assign in_item.byte_value    = s_axis_tdata[7:0];
    assign in_item.pattern_index = s_axis_tdata[8 +: PAT_IDX_W];

    assign stall         = has_result && r_out_valid && !m_axis_tready;
    assign adv           = r_in_valid && !stall;
    assign s_axis_tready = !r_in_valid || !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= in_item;
        end
    end

    lsf_matcher u_matcher (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_status (status)
    );

    lsf_line_ctrl u_line_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_item       (r_in_item),
        .i_cfg        (r_cfg),
        .i_status     (status),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && has_result) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out.selected_count, r_out.line_selected, r_out.line_number};
    assign m_axis_tuser  = r_out.result_kind;
    assign m_axis_tlast  = 1'b1;

    `LSF_ASSERT(a_ready_when_empty, !r_in_valid |-> s_axis_tready, "input stage empty but not ready")
    `LSF_ASSERT(a_result_held, (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)), "pending result lost or changed")
    `LSF_ASSERT(a_line_number_nonzero, (m_axis_tvalid && m_axis_tuser == KIND_LINE) |-> (m_axis_tdata[31:0] != '0), "line report with line number zero")
    `LSF_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !m_axis_tvalid, "output valid right after reset")

endmodule

// ===== sv/lsf_matcher.sv =====
// ---------------------------------------------------------------------------
// lsf_matcher
// Pattern store and shift-and match vector, a text byte a cycle when enabled.
// ---------------------------------------------------------------------------
module lsf_matcher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  lsf_pkg::t_item        i_item,
    input  lsf_pkg::t_cfg         i_cfg,
    output lsf_pkg::t_match_status o_status
);
    import lsf_pkg::*;

    logic [7:0]             r_pat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_pm;
    logic [PATTERN_MAX-1:0] n_pm;
    logic                   r_has;
    logic [PATTERN_MAX-1:0] eq;
    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       len_m1;
    logic [7:0]             t_byte;
    logic                   hit_now;

    assign len_eff = (i_cfg.pattern_length > LEN_W'(PATTERN_MAX)) ?
                     LEN_W'(PATTERN_MAX) : i_cfg.pattern_length;
    assign len_m1  = len_eff - LEN_W'(1);
    assign t_byte  = fold(i_item.byte_value, i_cfg.ignore_case);

    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            eq[j] = (fold(r_pat[j], i_cfg.ignore_case) == t_byte);
            if (LEN_W'(j) < len_eff) begin
                n_pm[j] = (j == 0) ? eq[j] : (r_pm[(j == 0) ? 0 : j-1] & eq[j]);
            end else begin
                n_pm[j] = r_pm[j];
            end
        end
    end

    // only a text byte goes through the matcher
    assign hit_now           = (i_item.action == ACT_TEXT) && (len_eff != '0) &&
                               n_pm[len_m1[PAT_IDX_W-1:0]];
    assign o_status.line_hit = r_has | hit_now;
    assign o_status.len_zero = (len_eff == '0);

    always_ff @(posedge i_clk) begin
        if (i_en && i_item.action == ACT_LOAD) begin
            r_pat[i_item.pattern_index] <= i_item.byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm  <= '0;
            r_has <= 1'b0;
        end else if (i_en) begin
            if (i_item.action == ACT_TEXT) begin
                if (i_item.byte_value == NEWLINE) begin
                    r_pm  <= '0;
                    r_has <= 1'b0;
                end else if (len_eff != '0) begin
                    r_pm  <= n_pm;
                    r_has <= o_status.line_hit;
                end
            end else if (i_item.action == ACT_END) begin
                r_pm  <= '0;
                r_has <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/lsf_line_ctrl.sv =====
// ---------------------------------------------------------------------------
// lsf_line_ctrl
// Line closing, saturating counters and result formation.
// ---------------------------------------------------------------------------
module lsf_line_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  lsf_pkg::t_item         i_item,
    input  lsf_pkg::t_cfg          i_cfg,
    input  lsf_pkg::t_match_status i_status,
    output logic                   o_has_result,
    output lsf_pkg::t_result       o_result
);
    import lsf_pkg::*;

    logic             r_open;
    logic [CNT_W-1:0] r_seen;
    logic [CNT_W-1:0] r_matched;
    logic             is_text;
    logic             is_end;
    logic             is_nl;
    logic             closing;
    logic             sel;
    logic [CNT_W-1:0] seen_inc;
    logic [CNT_W-1:0] matched_inc;
    logic [CNT_W-1:0] matched_after;

    assign is_text  = (i_item.action == ACT_TEXT);
    assign is_end   = (i_item.action == ACT_END);
    assign is_nl    = (i_item.byte_value == NEWLINE);
    assign closing  = (is_text && is_nl) || (is_end && r_open);
    assign sel      = (i_status.len_zero || i_status.line_hit) ^ i_cfg.invert_select;
    assign seen_inc = (r_seen == CNT_MAX) ? r_seen : r_seen + CNT_W'(1);
    assign matched_inc = (sel && r_matched != CNT_MAX) ? r_matched + CNT_W'(1) : r_matched;
    assign matched_after = closing ? matched_inc : r_matched;

    assign o_has_result = (closing && !i_cfg.count_only) || (is_end && i_cfg.count_only);

    always_comb begin
        o_result = '0;
        if (is_end && i_cfg.count_only) begin
            o_result.result_kind    = KIND_COUNT;
            o_result.selected_count = matched_after;
        end else begin
            o_result.result_kind   = KIND_LINE;
            o_result.line_number   = seen_inc;
            o_result.line_selected = sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_seen    <= '0;
            r_matched <= '0;
        end else if (i_en) begin
            if (is_text) begin
                r_open <= !is_nl;
                if (is_nl) begin
                    r_seen    <= seen_inc;
                    r_matched <= matched_inc;
                end
            end else if (is_end) begin
                r_open    <= 1'b0;
                r_seen    <= '0;
                r_matched <= '0;
            end
        end
    end

endmodule

// ===== bench/lsf_result_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsf_result_checker
// Watches the config port and both stream channels of the line filter,
// tracks the pattern store, shift-and match vector and line counters on its
// own, and compares every result transfer field by field with the oldest
// predicted one. Failures, pending predictions and compared results are
// handed to the testbench top.
// ---------------------------------------------------------------------------
module lsf_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // byte_value[7:0], pattern_index[13:8]
    input  logic [1:0]                     s_axis_tuser,  // action[1:0]
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [71:0]                    m_axis_tdata,  // line_number[31:0], line_selected[32],
                                                          // selected_count[64:33]
    input  logic                           m_axis_tuser,  // result_kind[0]
    input  logic                           m_axis_tlast,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import lsf_pkg::*;

    typedef struct {
        bit        kind;
        bit [31:0] line_no;
        bit        sel;
        bit [31:0] total;
        bit        last;
    } t_line_result;

    t_line_result expected_results[$];

    bit                   fold_en;
    bit                   invert_en;
    bit                   count_mode;
    bit [CFG_DATA_W-1:0]  pat_len;
    bit [7:0]             pattern_copy [PATTERN_MAX];
    bit [PATTERN_MAX-1:0] partial;
    bit                   hit;
    bit                   line_open;
    bit [CNT_W-1:0]       lines_closed;
    bit [CNT_W-1:0]       lines_picked;
    int                   fails = 0;
    int                   checked = 0;

    function automatic bit [7:0] fold_case(bit [7:0] c);
        if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic int active_len();
        return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    endfunction

    task automatic shift_byte(bit [7:0] b);
        int        n;
        bit [7:0]  t;
        n = active_len();
        t = fold_case(b);
        if (n != 0) begin
            for (int j = PATTERN_MAX - 1; j > 0; j--) begin
                if (j < n) begin
                    partial[j] = partial[j-1] && (fold_case(pattern_copy[j]) == t);
                end
            end
            partial[0] = (fold_case(pattern_copy[0]) == t);
            if (partial[n-1]) begin
                hit = 1'b1;
            end
        end
    endtask

    function automatic bit close_line(output t_line_result r);
        bit s;
        s = ((active_len() == 0) || hit) != invert_en;
        if (lines_closed != CNT_MAX) lines_closed++;
        if (s && lines_picked != CNT_MAX) lines_picked++;
        partial   = '0;
        hit       = 1'b0;
        line_open = 1'b0;
        r.kind    = KIND_LINE;
        r.line_no = lines_closed;
        r.sel     = s;
        r.total   = '0;
        r.last    = 1'b0;
        return !count_mode;
    endfunction

    task automatic predict_item(bit [1:0] act, bit [7:0] b, bit [PAT_IDX_W-1:0] idx);
        t_line_result r;
        bit           have;
        have = 1'b0;
        case (act)
            ACT_LOAD: begin
                pattern_copy[idx] = b;
            end
            ACT_TEXT: begin
                line_open = 1'b1;
                shift_byte(b);
                if (b == NEWLINE) have = close_line(r);
            end
            ACT_END: begin
                if (line_open) have = close_line(r);
                if (count_mode) begin
                    r.kind    = KIND_COUNT;
                    r.line_no = '0;
                    r.sel     = 1'b0;
                    r.total   = lines_picked;
                    have      = 1'b1;
                end
                partial      = '0;
                hit          = 1'b0;
                line_open    = 1'b0;
                lines_closed = '0;
                lines_picked = '0;
            end
            default: ;
        endcase
        if (have) begin
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fails++;
        end
    endtask

    task automatic compare_result();
        t_line_result r;
        if (expected_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual kind %0d line %0d sel %0d count %0d",
                     $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[32],
                     m_axis_tdata[64:33]);
            fails++;
        end else begin
            r = expected_results.pop_front();
            check_field("result_kind", r.kind, m_axis_tuser);
            check_field("line_number", r.line_no, m_axis_tdata[31:0]);
            check_field("line_selected", r.sel, m_axis_tdata[32]);
            check_field("selected_count", r.total, m_axis_tdata[64:33]);
            check_field("tlast", r.last, m_axis_tlast);
            check_field("tdata padding", 32'd0, {25'd0, m_axis_tdata[71:65]});
            checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fold_en      = 1'b0;
            invert_en    = 1'b0;
            count_mode   = 1'b0;
            pat_len      = '0;
            partial      = '0;
            hit          = 1'b0;
            line_open    = 1'b0;
            lines_closed = '0;
            lines_picked = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IGNORE_CASE:    fold_en    = i_cfg_data[0];
                    REG_INVERT_SELECT:  invert_en  = i_cfg_data[0];
                    REG_COUNT_ONLY:     count_mode = i_cfg_data[0];
                    REG_PATTERN_LENGTH: pat_len    = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[13:8]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                compare_result();
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
    end

endmodule

// ===== bench/tb_line_substring_filter_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_line_substring_filter_unit
// Stimulus and verdict for the line substring filter. A short directed
// sequence covers empty patterns, zero and newline pattern bytes, case
// folding, inversion, count mode and unfinished lines; random streams then
// load patterns of many lengths, embed full and partial copies in text, and
// change registers between and inside lines. Both stream sides stall at
// random; the checker instance predicts and compares.
// ---------------------------------------------------------------------------
module tb_line_substring_filter_unit;
    import lsf_pkg::*;

    localparam int         CLK_PERIOD   = 12;
    localparam int         ITEM_TARGET  = 1550;
    localparam int         LIMIT_CYCLES = 400000;
    localparam logic [1:0] ACT_NONE     = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [71:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    int fail_count;
    int results_pending;
    int results_checked;

    bit       calm = 1'b0;
    int       items_sent = 0;
    int       streams_done = 0;
    bit [7:0] cur_pat [PATTERN_MAX];
    int       pat_ready = 0;
    bit       cfg_ic;
    bit       cfg_inv;
    bit       cfg_cnt;
    int       cfg_len;

    line_substring_filter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lsf_result_checker u_result_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (results_pending),
        .o_checked     (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 32);
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic push_transfer(logic [1:0] act, logic [7:0] val, logic [PAT_IDX_W-1:0] idx);
        if (!calm) begin
            while ($urandom_range(99) < 32) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, val};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (act != ACT_NONE) items_sent++;
    endtask

    // drain: every expected result back, then let result-less transfers settle
    task automatic hold_off();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(bit ic, bit inv, bit cnt, int len);
        hold_off();
        write_reg(REG_IGNORE_CASE, CFG_DATA_W'(ic));
        write_reg(REG_INVERT_SELECT, CFG_DATA_W'(inv));
        write_reg(REG_COUNT_ONLY, CFG_DATA_W'(cnt));
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        cfg_ic  = ic;
        cfg_inv = inv;
        cfg_cnt = cnt;
        cfg_len = len;
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) begin
            push_transfer(ACT_TEXT, s[k], '0);
        end
    endtask

    function automatic bit [7:0] pick_letter();
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(1));
    endfunction

    function automatic bit [7:0] pick_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 40) return pick_letter();
        if (r < 50) return 8'h00;
        if (r < 58) return 8'hFF;
        if (r < 61) return NEWLINE;
        return 8'($urandom_range(255));
    endfunction

    function automatic bit [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(99);
        if (r < 60) return pick_letter();
        if (r < 68) return 8'h00;
        if (r < 73) return NEWLINE;
        return 8'($urandom_range(255));
    endfunction

    function automatic int pattern_span();
        return (cfg_len > PATTERN_MAX) ? PATTERN_MAX : cfg_len;
    endfunction

    task automatic load_pattern(int n);
        int start;
        int j;
        start = (n > 0) ? $urandom_range(n - 1) : 0;
        for (int k = 0; k < n; k++) begin
            j = (start + k) % n;
            cur_pat[j] = pick_pattern_byte();
            push_transfer(ACT_LOAD, cur_pat[j], PAT_IDX_W'(j));
        end
        if (n > pat_ready) pat_ready = n;
    endtask

    // random text, with or without a full or truncated copy of the pattern in it
    task automatic emit_line(bit closed);
        int       n_pre;
        int       n_post;
        int       m;
        int       span;
        bit [7:0] b;
        span   = pattern_span();
        n_pre  = $urandom_range(0, 6);
        n_post = $urandom_range(0, 6);
        m      = 0;
        if (span > 0 && $urandom_range(99) < 55) begin
            m = ($urandom_range(99) < 25) ? $urandom_range(0, span - 1) : span;
        end
        for (int k = 0; k < n_pre; k++) begin
            push_transfer(ACT_TEXT, pick_text_byte(), PAT_IDX_W'($urandom_range(63)));
        end
        for (int k = 0; k < m; k++) begin
            b = cur_pat[k];
            if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
                    && $urandom_range(99) < (cfg_ic ? 50 : 5)) begin
                b = b ^ 8'h20;
            end
            push_transfer(ACT_TEXT, b, PAT_IDX_W'($urandom_range(63)));
        end
        for (int k = 0; k < n_post; k++) begin
            push_transfer(ACT_TEXT, pick_text_byte(), PAT_IDX_W'($urandom_range(63)));
        end
        if (closed) push_transfer(ACT_TEXT, NEWLINE, PAT_IDX_W'($urandom_range(63)));
    endtask

    task automatic run_stream(int want_len);
        int       len;
        int       span;
        int       r;
        int       nlines;
        int       idx;
        bit [7:0] b;
        calm = (items_sent >= 600) && (items_sent < 850);
        if (want_len >= 0) begin
            len = want_len;
        end else begin
            r = $urandom_range(99);
            if (r < 8)       len = 0;
            else if (r < 14) len = PATTERN_MAX;
            else if (r < 18) len = $urandom_range(PATTERN_MAX + 1, 127);
            else if (r < 30) len = $urandom_range(7, 24);
            else             len = $urandom_range(1, 5);
        end
        span = (len > PATTERN_MAX) ? PATTERN_MAX : len;
        if (span > pat_ready || $urandom_range(99) < 60) load_pattern(span);
        if ($urandom_range(99) < 10) begin
            idx = $urandom_range(PATTERN_MAX - 1);
            b   = pick_pattern_byte();
            cur_pat[idx] = b;
            push_transfer(ACT_LOAD, b, PAT_IDX_W'(idx));
        end
        set_config($urandom_range(1), $urandom_range(1), $urandom_range(1), len);
        nlines = $urandom_range(1, 8);
        for (int i = 0; i < nlines; i++) begin
            // register change with a line possibly open
            if ($urandom_range(99) < 8) begin
                hold_off();
                cfg_ic  = $urandom_range(1);
                cfg_inv = $urandom_range(1);
                write_reg(REG_IGNORE_CASE, CFG_DATA_W'(cfg_ic));
                write_reg(REG_INVERT_SELECT, CFG_DATA_W'(cfg_inv));
                if ($urandom_range(1)) begin
                    cfg_cnt = ~cfg_cnt;
                    write_reg(REG_COUNT_ONLY, CFG_DATA_W'(cfg_cnt));
                end
            end
            if ($urandom_range(99) < 4) begin
                push_transfer(ACT_NONE, 8'($urandom_range(255)), PAT_IDX_W'($urandom_range(63)));
            end
            emit_line((i < nlines - 1) || ($urandom_range(99) < 75));
        end
        if ($urandom_range(99) < 85) begin
            push_transfer(ACT_END, 8'($urandom_range(255)), PAT_IDX_W'($urandom_range(63)));
        end
        streams_done++;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern selects every line, unknown action ignored,
        // unfinished line closed by end of input
        set_config(1'b0, 1'b0, 1'b0, 0);
        send_text("ab\n");
        send_text("\n");
        push_transfer(ACT_NONE, 8'hFF, 6'd63);
        send_text("z");
        push_transfer(ACT_END, 8'h00, 6'd0);

        // zero byte, upper-case letter and newline inside the pattern
        cur_pat[0] = 8'h00;
        cur_pat[1] = "K";
        cur_pat[2] = NEWLINE;
        for (int k = 0; k < 3; k++) begin
            push_transfer(ACT_LOAD, cur_pat[k], PAT_IDX_W'(k));
        end
        pat_ready = 3;
        set_config(1'b1, 1'b0, 1'b0, 3);
        push_transfer(ACT_TEXT, 8'h00, '0);
        send_text("k\n");
        push_transfer(ACT_TEXT, 8'hFF, '0);
        send_text("K\n");
        push_transfer(ACT_TEXT, 8'h00, '0);
        hold_off();
        write_reg(REG_IGNORE_CASE, CFG_DATA_W'(1'b0));
        send_text("k\n");
        set_config(1'b0, 1'b1, 1'b1, 3);
        push_transfer(ACT_TEXT, 8'h00, '0);
        send_text("K\nq");
        push_transfer(ACT_END, 8'h00, '0);

        run_stream(127);
        run_stream(PATTERN_MAX);
        while (items_sent < ITEM_TARGET) begin
            run_stream(-1);
        end
        calm = 1'b0;
        hold_off();

        $display("Run covered %0d input transfers in %0d random streams; %0d results compared.",
                 items_sent, streams_done, results_checked);
        $display("Patterns of length 0 to 127, case folding, inversion and count mode exercised.");
        if (fail_count == 0 && results_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== line_substring_filter_unit.f =====
+incdir+sv
sv/lsf_pkg.sv
sv/lsf_matcher.sv
sv/lsf_line_ctrl.sv
sv/line_substring_filter_unit.sv
bench/lsf_result_checker.sv
bench/tb_line_substring_filter_unit.sv
